// File: hw/rtl/fdwa_pkg.sv
// Shared types and constants for the flip detector with windowed average.
package fdwa_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int LIMIT_W   = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_LIMIT  = 2'd1;

  localparam logic [LIMIT_W-1:0] LEVEL_LIMIT_RST = 15'd300;
  localparam logic [LIMIT_W-1:0] FLIP_LIMIT_RST  = 15'd16000;

  // Phase strobes from the sequencer to the lanes and the merge stage
  typedef struct packed {
    logic load;      // write sample into ring, fetch the entry it replaces
    logic accum;     // update running sum
    logic div_load;  // take sign and magnitude of the sum
    logic div_step;  // one quotient bit
    logic full;      // ring was full, so the replaced entry leaves the sum
    logic commit;    // result taken into the output register
  } ctrl_t;

endpackage

// File: hw/rtl/fdwa_lane.sv
// One axis lane: ring buffer, running sum and bit-serial signed divider.
module fdwa_lane #(
  parameter int WINDOW = 20
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fdwa_pkg::ctrl_t                       ctrl,
  input  logic [(WINDOW > 1 ? $clog2(WINDOW) : 1)-1:0] slot,
  input  logic [$clog2(WINDOW+1)-1:0]           count,
  input  logic signed [fdwa_pkg::SAMPLE_W-1:0]  sample,
  output logic signed [fdwa_pkg::SAMPLE_W-1:0]  avg
);

  localparam int SW    = fdwa_pkg::SAMPLE_W;
  localparam int SUM_W = SW + $clog2(WINDOW);
  localparam int CW    = $clog2(WINDOW+1);

  logic signed [SW-1:0]    ring_r [WINDOW];
  logic signed [SW-1:0]    old_r;
  logic signed [SW-1:0]    samp_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [SUM_W-1:0]        dvd_r;
  logic [CW-1:0]           rem_r;
  logic                    neg_r;
  logic [CW:0]             rem_sh;
  logic [CW:0]             cnt_ext;
  logic [CW:0]             rem_sub;
  logic                    ge;
  logic [SW-1:0]           quo;

  // Store the new sample, fetch the one it overwrites
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ring_r[slot] <= sample;
      old_r        <= ring_r[slot];
      samp_r       <= sample;
    end
  end

  // Add the new sample, drop the oldest once the window is full
  always_comb begin
    sum_nxt = sum_r + SUM_W'(samp_r);
    if (ctrl.full) begin
      sum_nxt = sum_nxt - SUM_W'(old_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctrl.accum) begin
      sum_r <= sum_nxt;
    end
  end

  // Restoring division of the magnitude, one bit per cycle
  assign rem_sh  = {rem_r, dvd_r[SUM_W-1]};
  assign cnt_ext = {1'b0, count};
  assign ge      = (rem_sh >= cnt_ext);
  assign rem_sub = rem_sh - cnt_ext;

  always_ff @(posedge clk) begin
    if (ctrl.div_load) begin
      neg_r <= sum_r[SUM_W-1];
      dvd_r <= sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
      rem_r <= '0;
    end else if (ctrl.div_step) begin
      rem_r <= ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
      dvd_r <= {dvd_r[SUM_W-2:0], ge};
    end
  end

  // Restore the sign, truncating toward zero
  assign quo = dvd_r[SW-1:0];
  assign avg = neg_r ? -quo : quo;

endmodule

// File: hw/rtl/fdwa_merge.sv
// Merge stage: level test on X and Z, flip test on Y, orientation flag.
module fdwa_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 commit,
  input  logic [fdwa_pkg::LIMIT_W-1:0]         level_limit,
  input  logic [fdwa_pkg::LIMIT_W-1:0]         flip_limit,
  input  logic signed [fdwa_pkg::SAMPLE_W-1:0] avg_x,
  input  logic signed [fdwa_pkg::SAMPLE_W-1:0] avg_y,
  input  logic signed [fdwa_pkg::SAMPLE_W-1:0] avg_z,
  output logic                                 flag_nxt
);

  localparam int CMP_W = fdwa_pkg::SAMPLE_W + 1;

  logic signed [CMP_W-1:0] lev;
  logic signed [CMP_W-1:0] flp;
  logic signed [CMP_W-1:0] ax;
  logic signed [CMP_W-1:0] ay;
  logic signed [CMP_W-1:0] az;
  logic                    level_ok;
  logic                    turned_over_r;

  assign lev = signed'({2'b00, level_limit});
  assign flp = signed'({2'b00, flip_limit});
  assign ax  = CMP_W'(avg_x);
  assign ay  = CMP_W'(avg_y);
  assign az  = CMP_W'(avg_z);

  assign level_ok = (ax > -lev) && (ax < lev) && (az > -lev) && (az < lev);

  // While X and Z are level: clear on strongly negative Y, set on strongly positive Y; else hold
  always_comb begin
    flag_nxt = turned_over_r;
    if (level_ok) begin
      if (ay < -flp) begin
        flag_nxt = 1'b0;
      end
      if (ay > flp) begin
        flag_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turned_over_r <= 1'b0;
    end else if (commit) begin
      turned_over_r <= flag_nxt;
    end
  end

endmodule

// File: hw/rtl/flip_detect_window_average.sv
// Top level: sequencer, configuration registers, three axis lanes and merge stage.
// One sample is in work at a time. The transfer edge writes the ring and fetches the
// replaced entry; then S_ACC updates the running sum, S_DLOAD loads the divider,
// S_DIV runs the restoring divider of each lane (one quotient bit per sum bit), and
// S_DONE commits. The next sample is taken once the last one has committed. The
// divide by the fill count is the longest phase; the three axes divide side by side.
// A finished result waits in the output register while the next sample is taken;
// commit of the following one stalls until that result is transferred.
// Configuration writes are always accepted; indices beyond the register list are
// ignored.
module flip_detect_window_average #(
  parameter int WINDOW = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [fdwa_pkg::SAMPLE_W-1:0] in_accel_x,
  input  logic signed [fdwa_pkg::SAMPLE_W-1:0] in_accel_y,
  input  logic signed [fdwa_pkg::SAMPLE_W-1:0] in_accel_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_flipped,
  output logic signed [fdwa_pkg::SAMPLE_W-1:0] out_avg_x,
  output logic signed [fdwa_pkg::SAMPLE_W-1:0] out_avg_y,
  output logic signed [fdwa_pkg::SAMPLE_W-1:0] out_avg_z,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fdwa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fdwa_pkg::LIMIT_W-1:0]         cfg_data
);

  localparam int SW     = fdwa_pkg::SAMPLE_W;
  localparam int SUM_W  = SW + $clog2(WINDOW);
  localparam int CW     = $clog2(WINDOW+1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int STEP_W = $clog2(SUM_W+1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DLOAD,
    S_DIV,
    S_DONE
  } state_t;

  state_t                         state_r;
  logic [SLOT_W-1:0]              slot_r;
  logic [CW-1:0]                  fill_r;
  logic                           full_r;
  logic [STEP_W-1:0]              step_r;
  logic [fdwa_pkg::LIMIT_W-1:0]   level_limit_r;
  logic [fdwa_pkg::LIMIT_W-1:0]   flip_limit_r;
  logic                           out_valid_r;
  logic                           out_flipped_r;
  logic signed [SW-1:0]           out_avg_x_r;
  logic signed [SW-1:0]           out_avg_y_r;
  logic signed [SW-1:0]           out_avg_z_r;
  fdwa_pkg::ctrl_t                ctrl;
  logic signed [SW-1:0]           avg_x;
  logic signed [SW-1:0]           avg_y;
  logic signed [SW-1:0]           avg_z;
  logic                           flag_nxt;
  logic                           in_xfer;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Phase strobes
  always_comb begin
    ctrl.load     = in_xfer;
    ctrl.accum    = (state_r == S_ACC);
    ctrl.div_load = (state_r == S_DLOAD);
    ctrl.div_step = (state_r == S_DIV);
    ctrl.full     = full_r;
    ctrl.commit   = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_limit_r <= fdwa_pkg::LEVEL_LIMIT_RST;
      flip_limit_r  <= fdwa_pkg::FLIP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fdwa_pkg::REG_LEVEL_LIMIT: level_limit_r <= cfg_data;
        fdwa_pkg::REG_FLIP_LIMIT:  flip_limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Ring position and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      fill_r <= '0;
      full_r <= 1'b0;
    end else if (in_xfer) begin
      full_r <= (fill_r == CW'(WINDOW));
      if (fill_r != CW'(WINDOW)) begin
        fill_r <= fill_r + 1'b1;
      end
      if (slot_r == SLOT_W'(WINDOW - 1)) begin
        slot_r <= '0;
      end else begin
        slot_r <= slot_r + 1'b1;
      end
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise valid on commit, drop it once the result is transferred
      if (ctrl.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          state_r <= S_DLOAD;
        end
        S_DLOAD: begin
          step_r  <= STEP_W'(SUM_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (ctrl.commit) begin
            out_flipped_r <= flag_nxt;
            out_avg_x_r   <= avg_x;
            out_avg_y_r   <= avg_y;
            out_avg_z_r   <= avg_z;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  fdwa_lane #(.WINDOW(WINDOW)) u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .slot   (slot_r),
    .count  (fill_r),
    .sample (in_accel_x),
    .avg    (avg_x)
  );

  fdwa_lane #(.WINDOW(WINDOW)) u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .slot   (slot_r),
    .count  (fill_r),
    .sample (in_accel_y),
    .avg    (avg_y)
  );

  fdwa_lane #(.WINDOW(WINDOW)) u_lane_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .slot   (slot_r),
    .count  (fill_r),
    .sample (in_accel_z),
    .avg    (avg_z)
  );

  fdwa_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .commit      (ctrl.commit),
    .level_limit (level_limit_r),
    .flip_limit  (flip_limit_r),
    .avg_x       (avg_x),
    .avg_y       (avg_y),
    .avg_z       (avg_z),
    .flag_nxt    (flag_nxt)
  );

  assign out_valid   = out_valid_r;
  assign out_flipped = out_flipped_r;
  assign out_avg_x   = out_avg_x_r;
  assign out_avg_y   = out_avg_y_r;
  assign out_avg_z   = out_avg_z_r;

  // Fill count never passes the window length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(WINDOW))
    else $error("fill count beyond window");

  // A sample in work blocks the next transfer
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("second sample taken while one is in work");

  // The oldest entry leaves the sum only once the window is full
  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (full_r && state_r != S_IDLE) |-> (fill_r == CW'(WINDOW)))
    else $error("replaced entry dropped before window filled");

  // A committed result is offered next cycle
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.commit |=> out_valid)
    else $error("committed result not offered");

endmodule
